// ----- rtl/stt_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the tokeniser.
package stt_pkg;

  localparam int MAX_TEXT = 32;
  localparam int LEN_W    = $clog2(MAX_TEXT + 2);
  localparam int IDX_W    = $clog2(MAX_TEXT);
  localparam int VAL_W    = 31;
  localparam int LINE_W   = 16;
  localparam int KIND_W   = 4;
  localparam int CHAR_W   = 8;

  localparam logic [VAL_W-1:0] INT_SAT = {VAL_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_KEYWORD = 4'd1;
  localparam logic [KIND_W-1:0] KIND_INT     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_STRING  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OPER    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PUNCT   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_BAD     = 4'd6;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_TOOLONG = 4'd8;
  localparam logic [KIND_W-1:0] KIND_END     = 4'd9;

  typedef enum logic [1:0] {
    LEN_HOLD,
    LEN_CLEAR,
    LEN_INC,
    LEN_OVER
  } len_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_DIGIT,
    ACC_MAC
  } acc_op_e;

  typedef enum logic [1:0] {
    OUT_PRE,
    OUT_TEXT,
    OUT_POST
  } out_sel_e;

  typedef struct packed {
    logic letter;
    logic digit;
    logic quote;
    logic blank;
    logic newline;
    logic oper;
    logic punct;
    logic end_flag;
    logic len_zero;
    logic len_lt_max;
    logic len_eq_max;
    logic kw_hit;
    logic out_free;
    logic dump_last;
  } stt_status_t;

  typedef struct packed {
    logic              accept;
    len_op_e           len_op;
    logic              store_we;
    acc_op_e           acc_op;
    logic              line_inc;
    logic [KIND_W-1:0] pre_kind;
    logic              pre_from_acc;
    logic              pre_empty;
    logic [KIND_W-1:0] post_kind;
    logic              post_from_char;
    logic              rd_en;
    logic              out_load;
    out_sel_e          out_sel;
    logic              out_lor;
  } stt_cmd_t;

endpackage

// ----- rtl/stt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stt_ctrl.sv -----
// Tokeniser controller: lexer mode, per-beat decisions and result sequencing.
module stt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stt_pkg::stt_status_t status_i,
  output stt_pkg::stt_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RADDR = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_PRE   = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_IDENT = 3'd1;
  localparam logic [2:0] M_NUM   = 3'd2;
  localparam logic [2:0] M_STR   = 3'd3;
  localparam logic [2:0] M_HALT  = 3'd4;

  localparam logic [1:0] PRE_NONE = 2'd0;
  localparam logic [1:0] PRE_TEXT = 2'd1;
  localparam logic [1:0] PRE_ONE  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [2:0] mode_q, mode_d;
  logic       post_q, post_d;
  logic       accept;
  logic       do_flush, do_start, do_append;
  logic [1:0] pre_sel;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    post_d    = post_q;
    do_flush  = 1'b0;
    do_start  = 1'b0;
    do_append = 1'b0;
    pre_sel   = PRE_NONE;

    cmd_o.accept         = accept;
    cmd_o.len_op         = stt_pkg::LEN_HOLD;
    cmd_o.store_we       = 1'b0;
    cmd_o.acc_op         = stt_pkg::ACC_HOLD;
    cmd_o.line_inc       = 1'b0;
    cmd_o.pre_kind       = stt_pkg::KIND_IDENT;
    cmd_o.pre_from_acc   = 1'b0;
    cmd_o.pre_empty      = 1'b0;
    cmd_o.post_kind      = stt_pkg::KIND_END;
    cmd_o.post_from_char = 1'b0;
    cmd_o.rd_en          = 1'b0;
    cmd_o.out_load       = 1'b0;
    cmd_o.out_sel        = stt_pkg::OUT_POST;
    cmd_o.out_lor        = 1'b0;

    // Decide what this beat does to the lexer state
    if (accept && (mode_q != M_HALT)) begin
      post_d = 1'b0;
      if (status_i.end_flag) begin
        if (mode_q == M_STR) begin
          post_d          = 1'b1;
          cmd_o.post_kind = stt_pkg::KIND_OPEN;
          cmd_o.len_op    = stt_pkg::LEN_CLEAR;
          mode_d          = M_HALT;
        end else begin
          do_flush        = 1'b1;
          post_d          = 1'b1;
          cmd_o.post_kind = stt_pkg::KIND_END;
        end
      end else if (mode_q == M_STR) begin
        if (status_i.quote) begin
          pre_sel         = status_i.len_zero ? PRE_ONE : PRE_TEXT;
          cmd_o.pre_kind  = stt_pkg::KIND_STRING;
          cmd_o.pre_empty = status_i.len_zero;
          cmd_o.len_op    = stt_pkg::LEN_CLEAR;
          mode_d          = M_IDLE;
        end else begin
          do_append = 1'b1;
        end
      end else if ((mode_q == M_IDENT) && (status_i.letter || status_i.digit)) begin
        do_append = 1'b1;
      end else if ((mode_q == M_NUM) && status_i.digit) begin
        cmd_o.acc_op = stt_pkg::ACC_MAC;
      end else begin
        do_flush = 1'b1;
        do_start = 1'b1;
      end
    end

    if (do_flush) begin
      if (mode_q == M_IDENT) begin
        pre_sel        = PRE_TEXT;
        cmd_o.pre_kind = status_i.kw_hit ? stt_pkg::KIND_KEYWORD : stt_pkg::KIND_IDENT;
      end else if (mode_q == M_NUM) begin
        pre_sel            = PRE_ONE;
        cmd_o.pre_kind     = stt_pkg::KIND_INT;
        cmd_o.pre_from_acc = 1'b1;
      end
      cmd_o.len_op = stt_pkg::LEN_CLEAR;
      cmd_o.acc_op = stt_pkg::ACC_CLEAR;
      mode_d       = M_IDLE;
    end

    if (do_start) begin
      priority if (status_i.letter) begin
        mode_d    = M_IDENT;
        do_append = 1'b1;
      end else if (status_i.digit) begin
        mode_d       = M_NUM;
        cmd_o.acc_op = stt_pkg::ACC_DIGIT;
      end else if (status_i.quote) begin
        mode_d = M_STR;
      end else if (status_i.newline) begin
        cmd_o.line_inc = 1'b1;
      end else if (status_i.oper) begin
        post_d               = 1'b1;
        cmd_o.post_kind      = stt_pkg::KIND_OPER;
        cmd_o.post_from_char = 1'b1;
      end else if (status_i.punct) begin
        post_d               = 1'b1;
        cmd_o.post_kind      = stt_pkg::KIND_PUNCT;
        cmd_o.post_from_char = 1'b1;
      end else if (status_i.blank) begin
        mode_d = M_IDLE;
      end else begin
        post_d               = 1'b1;
        cmd_o.post_kind      = stt_pkg::KIND_BAD;
        cmd_o.post_from_char = 1'b1;
        mode_d               = M_HALT;
      end
    end

    if (do_append) begin
      if (status_i.len_lt_max) begin
        cmd_o.store_we = 1'b1;
        cmd_o.len_op   = stt_pkg::LEN_INC;
      end else if (status_i.len_eq_max) begin
        cmd_o.len_op         = stt_pkg::LEN_OVER;
        post_d               = 1'b1;
        cmd_o.post_kind      = stt_pkg::KIND_TOOLONG;
        cmd_o.post_from_char = 1'b1;
      end
    end

    // Result sequencing
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (pre_sel == PRE_TEXT) begin
            state_d = S_RADDR;
          end else if (pre_sel == PRE_ONE) begin
            state_d = S_PRE;
          end else if (post_d && (mode_q != M_HALT)) begin
            state_d = S_POST;
          end
        end
      end
      S_RADDR: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RDATA;
      end
      S_RDATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = stt_pkg::OUT_TEXT;
          cmd_o.out_lor  = status_i.dump_last && !post_q;
          if (status_i.dump_last) begin
            state_d = post_q ? S_POST : S_IDLE;
          end else begin
            state_d = S_RADDR;
          end
        end
      end
      S_PRE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = stt_pkg::OUT_PRE;
          cmd_o.out_lor  = !post_q;
          state_d        = post_q ? S_POST : S_IDLE;
        end
      end
      S_POST: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = stt_pkg::OUT_POST;
          cmd_o.out_lor  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_IDLE;
      post_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      post_q  <= post_d;
    end
  end

endmodule

// ----- rtl/stt_dp.sv -----
// Tokeniser datapath: character classes, text store, counters and result register.
module stt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [stt_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                         end_of_input_i,
  input  stt_pkg::stt_cmd_t            cmd_i,
  output stt_pkg::stt_status_t         status_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [stt_pkg::KIND_W-1:0]   token_kind_o,
  output logic [stt_pkg::VAL_W-1:0]    token_value_o,
  output logic                         token_last_o,
  output logic                         token_empty_o,
  output logic [stt_pkg::LINE_W-1:0]   line_number_o,
  output logic                         last_of_run_o
);

  localparam int LEN_W  = stt_pkg::LEN_W;
  localparam int IDX_W  = stt_pkg::IDX_W;
  localparam int VAL_W  = stt_pkg::VAL_W;
  localparam int LINE_W = stt_pkg::LINE_W;
  localparam int KIND_W = stt_pkg::KIND_W;
  localparam int CHAR_W = stt_pkg::CHAR_W;
  localparam int MAC_W  = VAL_W + 4;
  localparam int NUM_KW = 4;

  localparam logic [1:0] KW_PRINT = 2'd0;
  localparam logic [1:0] KW_VOID  = 2'd1;
  localparam logic [1:0] KW_VAR   = 2'd2;
  localparam logic [1:0] KW_IF    = 2'd3;

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    unique case (k)
      KW_PRINT: n = 3'd5;
      KW_VOID:  n = 3'd4;
      KW_VAR:   n = 3'd3;
      KW_IF:    n = 3'd2;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [39:0] word;
    logic [7:0]  ch;
    unique case (k)
      KW_PRINT: word = 40'h7072696E74;
      KW_VOID:  word = 40'h766F696400;
      KW_VAR:   word = 40'h7661720000;
      KW_IF:    word = 40'h6966000000;
      default:  word = '0;
    endcase
    if (pos > 3'd4) begin
      ch = 8'h00;
    end else begin
      ch = word[8 * (4 - int'(pos)) +: 8];
    end
    return ch;
  endfunction

  logic [LEN_W-1:0]  len_q, len_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [NUM_KW-1:0] kw_ok_q, kw_ok_d;
  logic [NUM_KW-1:0] kw_match;
  logic              kw_hit;
  logic [LEN_W-1:0]  dump_len_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LINE_W-1:0] step_line_q;
  logic [KIND_W-1:0] pre_kind_q;
  logic [VAL_W-1:0]  pre_val_q;
  logic              pre_empty_q;
  logic [KIND_W-1:0] post_kind_q;
  logic [VAL_W-1:0]  post_val_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              last_q, last_d;
  logic              empty_q, empty_d;
  logic [LINE_W-1:0] out_line_q;
  logic              lor_q;
  logic [CHAR_W-1:0] rdata;
  logic [CHAR_W-1:0] c;
  logic [MAC_W-1:0]  mac_w;
  logic              mac_sat;
  logic              out_free;

  assign c = char_code_i;

  // Character classes
  assign status_o.letter     = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign status_o.digit      = (c >= 8'h30) && (c <= 8'h39);
  assign status_o.quote      = (c == 8'h22);
  assign status_o.blank      = (c == 8'h20) || (c == 8'h09);
  assign status_o.newline    = (c == 8'h0A);
  assign status_o.oper       = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h3D);
  assign status_o.punct      = (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) ||
                               (c == 8'h7D) || (c == 8'h3B);
  assign status_o.end_flag   = end_of_input_i;
  assign status_o.len_zero   = (len_q == '0);
  assign status_o.len_lt_max = (len_q < LEN_W'(stt_pkg::MAX_TEXT));
  assign status_o.len_eq_max = (len_q == LEN_W'(stt_pkg::MAX_TEXT));
  assign status_o.kw_hit     = kw_hit;
  assign status_o.out_free   = out_free;
  assign status_o.dump_last  = ((LEN_W'(idx_q) + LEN_W'(1)) == dump_len_q);

  assign out_free = !out_valid_q || !out_stall_i;

  // Track keyword prefixes as characters are stored
  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      kw_match[k] = (len_q < LEN_W'(kw_len(2'(k)))) &&
                    (c == kw_char(2'(k), len_q[2:0]));
      kw_ok_d[k]  = ((len_q == '0) || kw_ok_q[k]) && kw_match[k];
      kw_hit      = kw_hit || (kw_ok_q[k] && (len_q == LEN_W'(kw_len(2'(k)))));
    end
  end

  // Decimal accumulate: acc * 10 + digit, saturate on overflow
  assign mac_w   = {3'b000, acc_q, 1'b0} + {1'b0, acc_q, 3'b000} +
                   MAC_W'(c[3:0]);
  assign mac_sat = (mac_w > MAC_W'(stt_pkg::INT_SAT));

  always_comb begin
    unique case (cmd_i.len_op)
      stt_pkg::LEN_HOLD:  len_d = len_q;
      stt_pkg::LEN_CLEAR: len_d = '0;
      stt_pkg::LEN_INC:   len_d = len_q + LEN_W'(1);
      stt_pkg::LEN_OVER:  len_d = LEN_W'(stt_pkg::MAX_TEXT + 1);
      default:            len_d = len_q;
    endcase

    unique case (cmd_i.acc_op)
      stt_pkg::ACC_HOLD:  acc_d = acc_q;
      stt_pkg::ACC_CLEAR: acc_d = '0;
      stt_pkg::ACC_DIGIT: acc_d = VAL_W'(c[3:0]);
      stt_pkg::ACC_MAC:   acc_d = mac_sat ? stt_pkg::INT_SAT : mac_w[VAL_W-1:0];
      default:            acc_d = acc_q;
    endcase

    line_d = line_q;
    if (cmd_i.line_inc && (line_q != {LINE_W{1'b1}})) begin
      line_d = line_q + LINE_W'(1);
    end

    unique case (cmd_i.out_sel)
      stt_pkg::OUT_PRE: begin
        kind_d  = pre_kind_q;
        val_d   = pre_val_q;
        last_d  = 1'b1;
        empty_d = pre_empty_q;
      end
      stt_pkg::OUT_TEXT: begin
        kind_d  = pre_kind_q;
        val_d   = VAL_W'(rdata);
        last_d  = status_o.dump_last;
        empty_d = 1'b0;
      end
      default: begin
        kind_d  = post_kind_q;
        val_d   = post_val_q;
        last_d  = 1'b1;
        empty_d = 1'b0;
      end
    endcase
  end

  stt_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(stt_pkg::MAX_TEXT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_we),
    .waddr_i(len_q[IDX_W-1:0]),
    .wdata_i(c),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      acc_q       <= '0;
      line_q      <= '0;
      kw_ok_q     <= '0;
      idx_q       <= '0;
      dump_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      acc_q  <= acc_d;
      line_q <= line_d;
      if (cmd_i.store_we) begin
        kw_ok_q <= kw_ok_d;
      end
      if (cmd_i.accept) begin
        idx_q      <= '0;
        dump_len_q <= (len_q > LEN_W'(stt_pkg::MAX_TEXT)) ?
                      LEN_W'(stt_pkg::MAX_TEXT) : len_q;
      end else if (cmd_i.out_load && (cmd_i.out_sel == stt_pkg::OUT_TEXT)) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      step_line_q <= line_q;
      pre_kind_q  <= cmd_i.pre_kind;
      pre_val_q   <= cmd_i.pre_from_acc ? acc_q : '0;
      pre_empty_q <= cmd_i.pre_empty;
      post_kind_q <= cmd_i.post_kind;
      post_val_q  <= cmd_i.post_from_char ? VAL_W'(c) : '0;
    end
    if (cmd_i.out_load) begin
      kind_q     <= kind_d;
      val_q      <= val_d;
      last_q     <= last_d;
      empty_q    <= empty_d;
      out_line_q <= step_line_q;
      lor_q      <= cmd_i.out_lor;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign token_value_o = val_q;
  assign token_last_o  = last_q;
  assign token_empty_o = empty_q;
  assign line_number_o = out_line_q;
  assign last_of_run_o = lor_q;

endmodule

// ----- rtl/source_text_tokenizer_unit.sv -----
// Streaming source-text tokeniser: one byte per input beat, tokens out one result per beat.
// A byte giving no result leaves the input open; a single result passes state S_PRE or S_POST into
// the result register, buffered text passes S_RADDR and S_RDATA for each character (each needs a
// read of the text store, one port, registered data). A byte yields its buffered text and up to two
// single results; the input stalls while they are stepped out, and an output stall holds them.
// Reset (rst_ni, async, active low) clears mode, counters and output valid; no clearing pass.
module source_text_tokenizer_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [stt_pkg::CHAR_W-1:0] char_code_i,
  input  logic                       end_of_input_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [stt_pkg::KIND_W-1:0] token_kind_o,
  output logic [stt_pkg::VAL_W-1:0]  token_value_o,
  output logic                       token_last_o,
  output logic                       token_empty_o,
  output logic [stt_pkg::LINE_W-1:0] line_number_o,
  output logic                       last_of_run_o
);

  // Command and status between the sequencer and the datapath
  stt_pkg::stt_cmd_t    cmd;
  stt_pkg::stt_status_t status;

  // Controller: holds the lexer mode, decides per input beat how the
  // state advances and which results follow, then steps them out in order
  // (buffered text first, then any single result).
  stt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: classifies the byte, keeps text length, number accumulator,
  // line count and keyword match, owns the text store and the result
  // register that parts the output from the sequencer.
  stt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (char_code_i),
    .end_of_input_i(end_of_input_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .token_last_o  (token_last_o),
    .token_empty_o (token_empty_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

  // An input beat is never taken while a result is being loaded
  a_accept_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.out_load)
    else $error("input accepted while a result was loaded");

  // An empty token is always a bare string result
  a_empty_is_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_empty_o) |->
      ((token_kind_o == stt_pkg::KIND_STRING) && (token_value_o == '0) && token_last_o))
    else $error("empty flag on a non-string result");

  // The final result of a beat also closes its token
  a_run_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> token_last_o)
    else $error("run ended inside a token");

  // After the last result of a beat is loaded the input is open again
  a_ready_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && cmd.out_lor) |=> !in_stall_o)
    else $error("input still stalled after the final result");

endmodule
